// ===== hdl/dlrt_pkg.sv =====
package dlrt_pkg;

    localparam int IN_SIZE_DEF  = 64;
    localparam int OUT_SIZE_DEF = 64;
    localparam int DIM          = 64;
    localparam int IDX_W        = 6;
    localparam int DATA_W       = 16;
    localparam int FRAC         = 12;
    localparam int LR_W         = 15;
    localparam int ACC_W        = 32;
    // Multiplier A operand: wide enough for the shifted d*p update term
    localparam int T_W          = DATA_W + 4;
    localparam logic [LR_W-1:0] LR_RESET = 15'd41;

    typedef enum logic [2:0] {
        OP_WEIGHT = 3'd0,
        OP_BIAS   = 3'd1,
        OP_INPUT  = 3'd2,
        OP_PREV   = 3'd3,
        OP_DERIV  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_RD,
        S_FWD_MAC,
        S_FWD_OUT,
        S_UPD_RD,
        S_UPD_T,
        S_UPD_WR,
        S_BIAS_WR,
        S_BWD_RD,
        S_BWD_MAC,
        S_BWD_OUT
    } t_state;

    // Clamp a wide signed value into 16 bits.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7fff;
        end else if (v < -32'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/dlrt_ram.sv =====
module dlrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/dlrt_mac.sv =====
module dlrt_mac import dlrt_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [T_W-1:0]    i_a,
    input  logic signed [DATA_W:0]   i_b,
    output logic signed [ACC_W-1:0]  o_prod
);
    logic signed [ACC_W+7:0] w_full;

    // Multiply, floor-shift by the fraction width, register
    assign w_full = (ACC_W+8)'(i_a) * (ACC_W+8)'(i_b);

    always_ff @(posedge i_clk) begin
        o_prod <= ACC_W'(w_full >>> FRAC);
    end
endmodule

// ===== hdl/dense_layer_relu_train_core.sv =====
// Channel  | Ports                                              | Handshake
// command  | i_operation i_row i_col i_value i_last             | i_start & !o_busy
// result   | o_kind o_index o_result_value o_final_res          | o_valid, one cycle
// config   | psel penable pwrite paddr pwdata prdata pready     | APB, pready high
// Each load is written to its RAM as it is accepted. A forward pass works
// through each output row with one shared multiplier reading the weight RAM
// one word at a time; a backward pass updates each row's weights and bias,
// then forms the transposed sum. Reset is synchronous, active low, clears
// control and restores the default learning rate. Results cannot be stalled.
module dense_layer_relu_train_core import dlrt_pkg::*; #(
    parameter int IN_SIZE  = IN_SIZE_DEF,
    parameter int OUT_SIZE = OUT_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [2:0]               i_operation,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    output logic                     o_kind,
    output logic [IDX_W-1:0]         o_index,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_final_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_r, n_r, r_c, n_c;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [DATA_W-1:0] r_d, n_d;
    logic [1:0] r_ph, n_ph;
    logic [LR_W-1:0] r_lr;
    logic r_valid, n_valid, r_kind, n_kind, r_fin, n_fin;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic signed [DATA_W-1:0] r_res, n_res;

    logic w_acc_cmd, w_row_ok, w_col_ok;
    logic [2*IDX_W-1:0] w_wad, w_wrd;
    logic w_wwe, w_bwe, w_xwe, w_pwe, w_dwe;
    logic [DATA_W-1:0] w_wwd, w_bwd, w_wq, w_bq, w_xq, w_pq, w_dq;
    logic [IDX_W-1:0] w_bad, w_xad, w_pad, w_dad, w_brd;
    logic signed [T_W-1:0] w_ma;
    logic signed [DATA_W:0] w_mb;
    logic signed [ACC_W-1:0] w_prod;

    assign pready   = 1'b1;
    assign prdata   = 32'(r_lr);
    assign o_busy   = (r_state != S_IDLE);
    assign w_acc_cmd = i_start && !o_busy;
    assign w_row_ok = 32'(i_row) < OUT_SIZE;
    assign w_col_ok = 32'(i_col) < IN_SIZE;

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_index = r_idx;
    assign o_result_value = r_res;
    assign o_final_res = r_fin;

    dlrt_ram #(.WIDTH(DATA_W), .DEPTH(DIM*DIM)) u_w (.i_clk, .i_we(w_wwe),
        .i_waddr(w_wad), .i_wdata(w_wwd), .i_raddr(w_wrd), .o_rdata(w_wq));
    dlrt_ram #(.WIDTH(DATA_W), .DEPTH(DIM)) u_b (.i_clk, .i_we(w_bwe),
        .i_waddr(w_bad), .i_wdata(w_bwd), .i_raddr(w_brd), .o_rdata(w_bq));
    dlrt_ram #(.WIDTH(DATA_W), .DEPTH(DIM)) u_x (.i_clk, .i_we(w_xwe),
        .i_waddr(i_col), .i_wdata(i_value), .i_raddr(w_xad), .o_rdata(w_xq));
    dlrt_ram #(.WIDTH(DATA_W), .DEPTH(DIM)) u_p (.i_clk, .i_we(w_pwe),
        .i_waddr(i_col), .i_wdata(i_value), .i_raddr(w_pad), .o_rdata(w_pq));
    dlrt_ram #(.WIDTH(DATA_W), .DEPTH(DIM)) u_d (.i_clk, .i_we(w_dwe),
        .i_waddr(i_row), .i_wdata(i_value), .i_raddr(w_dad), .o_rdata(w_dq));

    dlrt_mac u_mac (.i_clk, .i_a(w_ma), .i_b(w_mb), .o_prod(w_prod));

    // Learning rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
        end else if (psel && penable && pwrite && pready && !paddr) begin
            r_lr <= pwdata[LR_W-1:0];
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_r <= n_r; r_c <= n_c; r_acc <= n_acc; r_d <= n_d;
        r_ph <= n_ph; r_kind <= n_kind; r_fin <= n_fin; r_idx <= n_idx;
        r_res <= n_res;
    end

    // Next state, RAM ports and multiplier operands
    always_comb begin
        logic signed [ACC_W-1:0] v_sum;
        logic signed [DATA_W-1:0] v_s;
        n_state = r_state; n_r = r_r; n_c = r_c; n_acc = r_acc;
        n_d = r_d; n_ph = r_ph; n_valid = 1'b0; n_kind = r_kind;
        n_fin = r_fin; n_idx = r_idx; n_res = r_res;
        w_wwe = 1'b0; w_bwe = 1'b0; w_xwe = 1'b0; w_pwe = 1'b0; w_dwe = 1'b0;
        w_wad = {i_row, i_col}; w_wwd = i_value; w_bad = i_row; w_bwd = i_value;
        w_wrd = {r_r, r_c}; w_brd = r_r; w_xad = r_c; w_pad = r_c; w_dad = r_r;
        w_ma = T_W'($signed(w_wq)); w_mb = (DATA_W+1)'($signed(w_xq));
        v_sum = r_acc + w_prod;
        v_s = sat16(v_sum);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_cmd) begin
                    w_wwe = (i_operation == OP_WEIGHT) && w_row_ok && w_col_ok;
                    w_bwe = (i_operation == OP_BIAS) && w_row_ok;
                    w_xwe = (i_operation == OP_INPUT) && w_col_ok;
                    w_pwe = (i_operation == OP_PREV) && w_col_ok;
                    w_dwe = (i_operation == OP_DERIV) && w_row_ok;
                    n_r = '0; n_c = '0; n_ph = '0; n_acc = '0;
                    if (i_last && i_operation == OP_INPUT) begin
                        n_state = S_FWD_RD;
                    end else if (i_last && i_operation == OP_DERIV) begin
                        n_state = S_UPD_RD;
                    end
                end
            end
            // Forward: read state, then MAC phase 0 multiply, phase 1 accumulate
            S_FWD_RD: begin
                n_state = S_FWD_MAC; n_ph = 2'd0;
            end
            S_FWD_MAC: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_acc = v_sum;
                    if (32'(r_c) == IN_SIZE-1) begin
                        n_state = S_FWD_OUT;
                    end else begin
                        n_c = r_c + 1'b1; n_state = S_FWD_RD;
                    end
                end
            end
            S_FWD_OUT: begin
                v_s = sat16(r_acc + ACC_W'($signed(w_bq)));
                n_valid = 1'b1; n_kind = 1'b0; n_idx = r_r;
                n_res = v_s[DATA_W-1] ? '0 : v_s;
                n_fin = (32'(r_r) == OUT_SIZE-1);
                n_acc = '0; n_c = '0;
                if (n_fin) begin
                    n_state = S_IDLE;
                end else begin
                    n_r = r_r + 1'b1; n_state = S_FWD_RD;
                end
            end
            // Update: t = d*p, then w += t*lr; bias after each row
            S_UPD_RD: begin
                n_state = S_UPD_T; n_ph = 2'd0;
            end
            S_UPD_T: begin
                w_ma = T_W'($signed(w_dq)); w_mb = (DATA_W+1)'($signed(w_pq));
                n_d = w_dq;
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_acc = w_prod;
                    n_ph = 2'd0; n_state = S_UPD_WR;
                end
            end
            S_UPD_WR: begin
                w_ma = T_W'(r_acc); w_mb = (DATA_W+1)'({1'b0, r_lr});
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    w_wwe = 1'b1; w_wad = {r_r, r_c};
                    w_wwd = sat16(ACC_W'($signed(w_wq)) + w_prod);
                    if (32'(r_c) == IN_SIZE-1) begin
                        n_ph = 2'd0; n_state = S_BIAS_WR;
                    end else begin
                        n_c = r_c + 1'b1; n_state = S_UPD_RD;
                    end
                end
            end
            S_BIAS_WR: begin
                w_ma = T_W'(r_d); w_mb = (DATA_W+1)'({1'b0, r_lr});
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    w_bwe = 1'b1; w_bad = r_r;
                    w_bwd = sat16(ACC_W'($signed(w_bq)) + w_prod);
                    n_c = '0; n_ph = 2'd0;
                    if (32'(r_r) == OUT_SIZE-1) begin
                        n_r = '0; n_acc = '0; n_state = S_BWD_RD;
                    end else begin
                        n_r = r_r + 1'b1; n_state = S_UPD_RD;
                    end
                end
            end
            // Backward sum: g[c] = sum over rows of W*d, zero where p[c] <= 0
            S_BWD_RD: begin
                n_state = S_BWD_MAC; n_ph = 2'd0;
            end
            S_BWD_MAC: begin
                w_mb = (DATA_W+1)'($signed(w_dq));
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_acc = v_sum;
                    if (32'(r_r) == OUT_SIZE-1) begin
                        n_state = S_BWD_OUT;
                    end else begin
                        n_r = r_r + 1'b1; n_state = S_BWD_RD;
                    end
                end
            end
            S_BWD_OUT: begin
                v_s = sat16(r_acc);
                n_valid = 1'b1; n_kind = 1'b1; n_idx = r_c;
                n_res = (w_pq[DATA_W-1] || w_pq == '0) ? '0 : v_s;
                n_fin = (32'(r_c) == IN_SIZE-1);
                n_acc = '0; n_r = '0;
                if (n_fin) begin
                    n_state = S_IDLE;
                end else begin
                    n_c = r_c + 1'b1; n_state = S_BWD_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hdl/dlrt_checker.sv =====
module dlrt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_busy,
    input logic o_valid,
    input logic o_final_res,
    input logic o_kind
);
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_valid) else $error("busy after reset");
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_res |-> !o_busy) else $error("busy after final");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_busy) else $error("result while idle");
    a_kind_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && !$past(o_final_res) |-> $stable(o_kind))
        else $error("kind changed mid vector");
endmodule

bind dense_layer_relu_train_core dlrt_checker u_chk (.i_clk, .i_rst_n,
    .o_busy, .o_valid, .o_final_res, .o_kind);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dlrt_pkg::*;

    localparam int          NEURONS       = 64;
    localparam int          CYCLE_LIMIT   = 3000000;
    localparam int          CALM_ITEMS    = 1024;
    localparam logic [2:0]  OP_SPARE_LO   = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
    localparam logic        ADDR_LR       = 1'b0;
    localparam logic        KIND_ACT      = 1'b0;
    localparam logic        KIND_GRAD     = 1'b1;

    typedef struct {
        logic [2:0]               op;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_cmd;

    typedef struct {
        logic                     kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     final_res;
    } t_elem;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic [2:0]               i_operation = '0;
    logic [IDX_W-1:0]         i_row = '0;
    logic [IDX_W-1:0]         i_col = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last = 1'b0;
    logic                     o_valid;
    logic                     o_kind;
    logic [IDX_W-1:0]         o_index;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_final_res;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic                     paddr = 1'b0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    dense_layer_relu_train_core dut (.*);

    always #10 i_clk = ~i_clk;

    // Layer state as the predictor sees it
    logic signed [DATA_W-1:0] weights [NEURONS*NEURONS];
    logic signed [DATA_W-1:0] biases [NEURONS];
    logic signed [DATA_W-1:0] x_vec [NEURONS];
    logic signed [DATA_W-1:0] p_vec [NEURONS];
    logic signed [DATA_W-1:0] d_vec [NEURONS];
    logic [LR_W-1:0]          lr_model = LR_RESET;

    t_cmd  cmd_queue[$];
    t_elem results_due[$];
    int    errors = 0;
    int    calm_left = 0;
    longint unsigned cycles = 0;

    function automatic logic signed [DATA_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[DATA_W-1:0];
    endfunction

    function automatic void push_elem(logic kind, int idx, longint v, bit fin);
        t_elem e;
        e.kind      = kind;
        e.index     = idx[IDX_W-1:0];
        e.value     = clamp16(v);
        e.final_res = fin;
        results_due.push_back(e);
    endfunction

    // Forward pass: ReLU(W*x + b)
    function automatic void predict_forward();
        longint acc;
        for (int r = 0; r < NEURONS; r++) begin
            acc = 0;
            for (int c = 0; c < NEURONS; c++) begin
                acc += (longint'(weights[r*NEURONS+c]) * longint'(x_vec[c])) >>> FRAC;
            end
            acc = longint'(clamp16(acc + longint'(biases[r])));
            if (acc < 0) acc = 0;
            push_elem(KIND_ACT, r, acc, r == NEURONS - 1);
        end
    endfunction

    // Backward pass: SGD update, then masked W^T*d with new weights
    function automatic void predict_backward();
        longint acc;
        longint t;
        longint lr;
        lr = longint'(lr_model);
        for (int r = 0; r < NEURONS; r++) begin
            for (int c = 0; c < NEURONS; c++) begin
                t = (longint'(d_vec[r]) * longint'(p_vec[c])) >>> FRAC;
                weights[r*NEURONS+c] = clamp16(longint'(weights[r*NEURONS+c])
                                               + ((t * lr) >>> FRAC));
            end
            biases[r] = clamp16(longint'(biases[r]) + ((longint'(d_vec[r]) * lr) >>> FRAC));
        end
        for (int c = 0; c < NEURONS; c++) begin
            acc = 0;
            for (int r = 0; r < NEURONS; r++) begin
                acc += (longint'(weights[r*NEURONS+c]) * longint'(d_vec[r])) >>> FRAC;
            end
            if (p_vec[c] <= 0) acc = 0;
            push_elem(KIND_GRAD, c, acc, c == NEURONS - 1);
        end
    endfunction

    function automatic void apply_cmd(t_cmd cmd);
        case (cmd.op)
            OP_WEIGHT: weights[cmd.row*NEURONS+cmd.col] = cmd.value;
            OP_BIAS:   biases[cmd.row] = cmd.value;
            OP_INPUT: begin
                x_vec[cmd.col] = cmd.value;
                if (cmd.last) predict_forward();
            end
            OP_PREV:   p_vec[cmd.col] = cmd.value;
            OP_DERIV: begin
                d_vec[cmd.row] = cmd.value;
                if (cmd.last) predict_backward();
            end
            default: ;
        endcase
    endfunction

    // Driver: predict on each accepted transfer, then load the next one
    always @(posedge i_clk) begin
        t_cmd nxt;
        logic taken;
        taken = i_start && !o_busy;
        if (taken) begin
            apply_cmd('{i_operation, i_row, i_col, i_value, i_last});
        end
        if (!i_start || taken) begin
            if (cmd_queue.size() > 0 && (calm_left > 0 || $urandom_range(0, 99) >= 25)) begin
                nxt = cmd_queue.pop_front();
                if (calm_left > 0) calm_left--;
                i_operation <= nxt.op;
                i_row       <= nxt.row;
                i_col       <= nxt.col;
                i_value     <= nxt.value;
                i_last      <= nxt.last;
                i_start     <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                $display("%0t unexpected result: expected none, got kind %0d idx %0d val %0d",
                         $time, o_kind, o_index, o_result_value);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (o_kind !== e.kind || o_index !== e.index
                    || o_result_value !== e.value || o_final_res !== e.final_res) begin
                    $display({"%0t mismatch: expected kind %0d idx %0d val %0d fin %0d,",
                              " got kind %0d idx %0d val %0d fin %0d"},
                             $time, e.kind, e.index, e.value, e.final_res,
                             o_kind, o_index, o_result_value, o_final_res);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3, 4: return DATA_W'($urandom);
            default: return DATA_W'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    task automatic push_cmd(logic [2:0] op, int row, int col,
                            logic signed [DATA_W-1:0] v, logic last);
        cmd_queue.push_back('{op, row[IDX_W-1:0], col[IDX_W-1:0], v, last});
    endtask

    // Wait until every command has gone and every result has arrived
    task automatic drain();
        while (cmd_queue.size() > 0 || i_start || results_due.size() > 0 || o_busy)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_lr(logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        lr_model = v[LR_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_backward_pass();
        push_cmd(OP_DERIV, $urandom_range(0, NEURONS-1), 0, pick_value(), 1'b1);
    endtask

    initial begin
        int op_pick;
        logic [2:0] op;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every store so no pass reads an unwritten entry; start without gaps
        calm_left = CALM_ITEMS;
        for (int r = 0; r < NEURONS; r++) begin
            for (int c = 0; c < NEURONS; c++) begin
                push_cmd(OP_WEIGHT, r, c, pick_value(), 1'b0);
            end
        end
        for (int i = 0; i < NEURONS; i++) begin
            push_cmd(OP_BIAS, i, 0, pick_value(), 1'b0);
            push_cmd(OP_INPUT, 0, i, pick_value(), 1'b0);
            push_cmd(OP_PREV, 0, i, pick_value(), 1'b0);
            push_cmd(OP_DERIV, i, 0, pick_value(), 1'b0);
        end

        // Forward and backward at the reset step size
        push_cmd(OP_INPUT, 0, NEURONS-1, 16'sh7fff, 1'b1);
        push_cmd(OP_PREV, 0, 0, 16'sh8000, 1'b0);
        push_cmd(OP_PREV, 0, 1, 16'sh7fff, 1'b0);
        push_cmd(OP_PREV, 0, 2, '0, 1'b0);
        push_cmd(OP_DERIV, NEURONS-1, 0, 16'sh8000, 1'b1);
        // Spare codes and last on loads that cannot start a pass: no result; then a forward pass
        for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
            push_cmd(k[2:0], NEURONS-1, NEURONS-1, 16'sh7fff, 1'b1);
        end
        push_cmd(OP_WEIGHT, 0, 0, 16'sh8000, 1'b1);
        push_cmd(OP_BIAS, NEURONS-1, 0, 16'sh7fff, 1'b1);
        push_cmd(OP_PREV, 0, NEURONS-1, 16'sh0001, 1'b1);
        push_cmd(OP_INPUT, 0, 0, 16'sh8000, 1'b0);
        push_cmd(OP_INPUT, 0, 1, '0, 1'b1);
        drain();

        // Largest step size, then zero
        write_lr(32'h7fff);
        run_backward_pass();
        drain();
        write_lr(32'h0);
        run_backward_pass();
        push_cmd(OP_INPUT, 0, 5, pick_value(), 1'b1);
        drain();
        write_lr(32'h7fff8000 | $urandom_range(0, 32767));

        // Random traffic, mostly loads with the odd pass
        for (int n = 0; n < 200; n++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 5) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else op = 3'($urandom_range(0, 4));
            push_cmd(op, $urandom_range(0, NEURONS-1), $urandom_range(0, NEURONS-1),
                     pick_value(),
                     (op == OP_INPUT || op == OP_DERIV) ? ($urandom_range(0, 29) == 0)
                                                        : ($urandom_range(0, 3) == 0));
        end
        push_cmd(OP_INPUT, 0, $urandom_range(0, NEURONS-1), pick_value(), 1'b1);
        run_backward_pass();
        drain();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
